// ===== hdl/accm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accm_pkg: shared types and constants for the ccm engine
// sbox and xtime functions, register indexes, ctr flags and the aes core control struct
// ----------------------------------------------------------------------------
package accm_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_HIGH   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LOW    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NONCE_HIGH = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NONCE_LOW  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MSG_LEN    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECRYPT    = 3'd5;

   localparam logic [7:0] CTR_FLAGS = 8'h02;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } aes_ctl_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

// ===== hdl/aes_ccm_encrypt_verify.sv =====
`timescale 1ns / 1ps
// sequence: a payload beat runs a keystream pass then a mac pass before rsp_tvalid,
// after a b0 pass on a message's first beat; a finish beat runs a tag pass (after the
// b0 pass if first); a zero byte count beat runs no pass (the b0 pass only if first)
// a new beat is accepted only after the previous response is taken; the shared aes core
// runs one round per cycle and its passes never overlap
// reset: synchronous active high, clears state, csr registers, mac, counter and handshake
// ----------------------------------------------------------------------------
// aes_ccm_encrypt_verify: aes-128 ccm encrypt or decrypt and tag check
// one shared aes core computes b0, keystream, mac and tag steps in sequence
// ----------------------------------------------------------------------------
module aes_ccm_encrypt_verify #(
   parameter int unsigned TAG_BYTES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [135:0]                     req_tdata,  // block_high, block_low, byte_count
   input  logic                             req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [135:0]                     rsp_tdata,  // out_high, out_low, out_bytes
   output logic [1:0]                       rsp_tuser,  // is_final, tag_match
   input  logic                             csr_we,
   input  logic [accm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [accm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import accm_pkg::*;

   localparam logic [7:0] B0_FLAGS = 8'(((TAG_BYTES - 2) / 2) * 8 + 2);

   typedef enum logic [2:0] {
      S_IDLE, S_B0, S_KS, S_MAC, S_FIN, S_OUT
   } state_type;

   state_type    state_ff;
   logic [127:0] key_ff, data_ff, mac_ff, res_ff, ks_ff;
   logic [95:0]  nonce_ff;
   logic [23:0]  len_ff, ctr_ff;
   logic         dec_ff, started_ff, mode_ff, match_ff;
   logic [4:0]   n_ff, nbytes_ff;

   logic         aes_start;
   logic [127:0] aes_din, aes_dout, bmask, ctrblk, keystream_res, plain, tagv, tmask;
   logic [23:0]  len_up;
   logic [4:0]   n_sat;
   aes_ctl_type  aes_ctl;

   accm_aes_core u_core (
      .clock (clock),
      .reset (reset),
      .start (aes_start),
      .key   (key_ff),
      .din   (aes_din),
      .dout  (aes_dout),
      .ctl   (aes_ctl)
   );

   assign len_up = (len_ff + 24'd15) & 24'hfffff0;
   assign n_sat  = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         bmask[127-8*i -: 8] = (i < n_ff) ? 8'hff : 8'h00;
         tmask[127-8*i -: 8] = (i < TAG_BYTES) ? 8'hff : 8'h00;
      end
      ctrblk        = {CTR_FLAGS, nonce_ff, (mode_ff ? 24'd0 : ctr_ff)};
      keystream_res = (data_ff ^ aes_dout) & bmask;
      plain         = dec_ff ? keystream_res : (data_ff & bmask);
      tagv          = (mac_ff ^ aes_dout) & tmask;
   end

   // start pulses accompany state entry
   always_comb begin
      aes_start = 1'b0;
      aes_din   = ctrblk;
      unique case (state_ff)
         S_IDLE: begin
            if (started_ff) begin
               aes_din   = {CTR_FLAGS, nonce_ff, (req_tuser ? 24'd0 : ctr_ff)};
               aes_start = req_tvalid && (req_tuser || n_sat != 5'd0);
            end else begin
               aes_din   = {B0_FLAGS, nonce_ff, len_up};
               aes_start = req_tvalid;
            end
         end
         S_B0: begin
            aes_din = ctrblk;
            aes_start = aes_ctl.done && (mode_ff || n_ff != 5'd0);
         end
         S_KS: begin
            aes_din = mac_ff ^ plain;
            aes_start = aes_ctl.done;
         end
         S_MAC, S_FIN, S_OUT: begin
            aes_din = ctrblk;
         end
         default: aes_din = ctrblk;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && (started_ff || aes_start);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         key_ff     <= '0;
         nonce_ff   <= '0;
         len_ff     <= '0;
         dec_ff     <= 1'b0;
         started_ff <= 1'b0;
         ctr_ff     <= 24'd1;
         mac_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_KEY_HIGH:   key_ff[127:64] <= csr_wdata;
               CSR_KEY_LOW:    key_ff[63:0]   <= csr_wdata;
               CSR_NONCE_HIGH: nonce_ff[95:64] <= csr_wdata[31:0];
               CSR_NONCE_LOW:  nonce_ff[63:0]  <= csr_wdata;
               CSR_MSG_LEN:    len_ff <= csr_wdata[23:0];
               CSR_DECRYPT:    dec_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  data_ff <= {req_tdata[63:0], req_tdata[127:64]};
                  mode_ff <= req_tuser;
                  n_ff    <= n_sat;
                  if (!started_ff) begin
                     state_ff <= S_B0;
                  end else if (req_tuser || n_sat != 5'd0) begin
                     state_ff <= req_tuser ? S_FIN : S_KS;
                  end else begin
                     res_ff    <= '0;
                     nbytes_ff <= 5'd0;
                     match_ff  <= 1'b0;
                     state_ff  <= S_OUT;
                  end
               end
            end
            S_B0: begin
               if (aes_ctl.done) begin
                  mac_ff     <= aes_dout;
                  started_ff <= 1'b1;
                  if (mode_ff) begin
                     state_ff <= S_FIN;
                  end else if (n_ff != 5'd0) begin
                     state_ff <= S_KS;
                  end else begin
                     res_ff    <= '0;
                     nbytes_ff <= 5'd0;
                     match_ff  <= 1'b0;
                     state_ff  <= S_OUT;
                  end
               end
            end
            S_KS: begin
               if (aes_ctl.done) begin
                  res_ff    <= keystream_res;
                  nbytes_ff <= n_ff;
                  match_ff  <= 1'b0;
                  state_ff  <= S_MAC;
               end
            end
            S_MAC: begin
               if (aes_ctl.done) begin
                  mac_ff   <= aes_dout;
                  ctr_ff   <= ctr_ff + 24'd1;
                  state_ff <= S_OUT;
               end
            end
            S_FIN: begin
               if (aes_ctl.done) begin
                  if (dec_ff) begin
                     res_ff    <= '0;
                     nbytes_ff <= 5'd0;
                     match_ff  <= (tagv == (data_ff & tmask));
                  end else begin
                     res_ff    <= tagv;
                     nbytes_ff <= 5'(TAG_BYTES);
                     match_ff  <= 1'b0;
                  end
                  mac_ff     <= '0;
                  ctr_ff     <= 24'd1;
                  started_ff <= 1'b0;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // start is only taken in idle or on a done pulse, so the fsm follows directly
   always_comb begin
      rsp_tvalid = (state_ff == S_OUT);
      rsp_tdata  = {3'b000, nbytes_ff, res_ff[63:0], res_ff[127:64]};
      rsp_tuser  = {match_ff, mode_ff};
   end

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      aes_ctl.busy |-> !aes_start) else $error("aes restarted while busy");
   a_out_nocore: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !aes_ctl.busy) else $error("result shown while core runs");
   a_tag_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && !dec_ff) |-> (nbytes_ff == 5'(TAG_BYTES)))
      else $error("tag length wrong");
`endif

endmodule

// ===== hdl/accm_aes_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accm_aes_core: iterative aes-128 encrypt
// one round per cycle with on-the-fly key expansion, 128-bit big-endian words
// ----------------------------------------------------------------------------
module accm_aes_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [127:0]          key,
   input  logic [127:0]          din,
   output logic [127:0]          dout,
   output accm_pkg::aes_ctl_type ctl
);
   import accm_pkg::*;

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [127:0] sb, sr, mc, nk;
   logic [31:0]  tw;
   logic [7:0]   a0, a1, a2, a3, al;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sb[127-8*i -: 8] = sbox(state_ff[127-8*i -: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sr[127-32*c -: 8];
         a1 = sr[119-32*c -: 8];
         a2 = sr[111-32*c -: 8];
         a3 = sr[103-32*c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      tw = {sbox(rkey_ff[23:16]) ^ rcon_ff, sbox(rkey_ff[15:8]), sbox(rkey_ff[7:0]),
            sbox(rkey_ff[31:24])};
      nk[127:96] = rkey_ff[127:96] ^ tw;
      nk[95:64]  = rkey_ff[95:64] ^ nk[127:96];
      nk[63:32]  = rkey_ff[63:32] ^ nk[95:64];
      nk[31:0]   = rkey_ff[31:0] ^ nk[63:32];
   end

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         state_in = din ^ key;
         rkey_in  = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = ((round_ff == 4'd10) ? sr : mc) ^ nk;
         rkey_in  = nk;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
   end

   assign dout = state_ff;
   assign ctl  = '{start: start, busy: busy_ff, done: done_ff};

endmodule
